// ----- src/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helper functions of the barometer
// compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // fixed point and field widths
    localparam int FRAC      = 26;
    localparam int RAW_W     = 24;
    localparam int SC_W      = 32;
    localparam int TEMP_W    = 32;
    localparam int PRES_W    = 40;
    localparam int ALT_W     = 40;
    localparam int CFG_W     = 40;

    // long division: quotient bits handled per stage and number of stages
    localparam int DIV_W      = 40;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;
    localparam int SCALE_ST   = DIV_STAGES + 2;

    // Q.26 multiplier widths
    localparam int MQ_AW = 56;
    localparam int MQ_OW = 60;
    localparam int SUM_W = 62;

    // pipeline layout
    localparam int POLY_ST    = 9;
    localparam int ALT_ST     = 2;
    localparam int NUM_STAGES = SCALE_ST + POLY_ST + ALT_ST;

    // altitude constants: reference pressure in 1/16 Pa, 0.07874 in Q.24
    localparam logic [20:0] REF_P16 = 21'd1632000;
    localparam logic [20:0] ALT_K   = 21'd1321038;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_P_RATE,
        CFG_T_RATE,
        CFG_C0_C1,
        CFG_C00_C10,
        CFG_C01_C11,
        CFG_C20_C21,
        CFG_C30
    } cfg_index_t;

    // unpacked calibration coefficients
    typedef struct packed {
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c20;
        logic signed [15:0] c21;
        logic signed [15:0] c30;
    } coef_t;

    // scale factor is (2^(code+1) - 1) * 2^e, e = 19 for codes 0..3, 13 otherwise
    function automatic logic [7:0] rate_divisor(logic [2:0] code);
        rate_divisor = 8'((9'd2 << code) - 9'd1);
    endfunction

    // left shift that takes the sample to Q.26 over 2^e
    function automatic logic [3:0] rate_shift(logic [2:0] code);
        rate_shift = code[2] ? 4'd13 : 4'd7;
    endfunction

endpackage

// ----- src/bpc_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_scale
// Scales a raw sample by the reciprocal of its oversampling factor into
// Q5.26, rounded half away from zero, with saturation. Pipelined long
// division by the odd mantissa of the factor.
// ----------------------------------------------------------------------------
module bpc_scale (
    input  logic                                clk,
    input  logic [bpc_pkg::SCALE_ST-1:0]        ld,
    input  logic signed [bpc_pkg::RAW_W-1:0]    raw,
    input  logic [2:0]                          code,
    output logic signed [bpc_pkg::SC_W-1:0]     sc,
    output logic                                sat
);

    localparam int DW  = bpc_pkg::DIV_W;
    localparam int NDS = bpc_pkg::DIV_STAGES;

    logic [DW-1:0]             w_reg   [0:NDS];
    logic [7:0]                rem_reg [0:NDS];
    logic [7:0]                m_reg   [0:NDS];
    logic                      neg_reg [0:NDS];
    logic [bpc_pkg::RAW_W-1:0] mag;
    logic [7:0]                m_next;
    logic [DW-1:0]             w_next;
    logic signed [bpc_pkg::SC_W-1:0] sc_reg;
    logic signed [bpc_pkg::SC_W-1:0] sc_next;
    logic                      sat_reg;
    logic                      sat_next;
    logic [DW-1:0]             q;

    // restoring division, eight quotient bits
    function automatic logic [DW+7:0] div_step(logic [7:0] rem_in, logic [DW-1:0] w_in,
                                               logic [7:0] dv);
        logic [8:0]    r;
        logic [7:0]    rc;
        logic [DW-1:0] x;
        rc = rem_in;
        x  = w_in;
        for (int i = 0; i < bpc_pkg::DIV_STEPS; i++)
        begin
            r = {rc, x[DW-1]};
            x = {x[DW-2:0], 1'b0};
            if (r >= {1'b0, dv})
            begin
                r    = r - {1'b0, dv};
                x[0] = 1'b1;
            end
            rc = r[7:0];
        end
        div_step = {rc, x};
    endfunction

    // magnitude, shift to Q.26 and add the rounding half of the divisor
    always_comb
    begin
        mag    = raw[bpc_pkg::RAW_W-1] ? bpc_pkg::RAW_W'(-raw) : bpc_pkg::RAW_W'(raw);
        m_next = bpc_pkg::rate_divisor(code);
        w_next = (DW'(mag) << bpc_pkg::rate_shift(code)) + DW'(m_next[7:1]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            w_reg[0]   <= w_next;
            rem_reg[0] <= '0;
            m_reg[0]   <= m_next;
            neg_reg[0] <= raw[bpc_pkg::RAW_W-1];
        end
    end

    // division stages
    for (genvar g = 1; g <= NDS; g++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (ld[g])
            begin
                {rem_reg[g], w_reg[g]} <= div_step(rem_reg[g-1], w_reg[g-1], m_reg[g-1]);
                m_reg[g]               <= m_reg[g-1];
                neg_reg[g]             <= neg_reg[g-1];
            end
        end
    end

    // sign and clip to Q5.26
    always_comb
    begin
        q        = w_reg[NDS];
        sat_next = 1'b0;
        if (!neg_reg[NDS])
        begin
            if (q > DW'(40'h7FFF_FFFF))
            begin
                sc_next  = {1'b0, {(bpc_pkg::SC_W-1){1'b1}}};
                sat_next = 1'b1;
            end
            else
            begin
                sc_next = q[bpc_pkg::SC_W-1:0];
            end
        end
        else
        begin
            if (q > DW'(40'h8000_0000))
            begin
                sc_next  = {1'b1, {(bpc_pkg::SC_W-1){1'b0}}};
                sat_next = 1'b1;
            end
            else
            begin
                sc_next = -q[bpc_pkg::SC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NDS+1])
        begin
            sc_reg  <= sc_next;
            sat_reg <= sat_next;
        end
    end

    assign sc  = sc_reg;
    assign sat = sat_reg;

endmodule

// ----- src/bpc_mulq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_mulq
// Q.26 by Q.26 multiply with round half away from zero, in three stages:
// sign and magnitude, two partial products, combine and round.
// ----------------------------------------------------------------------------
module bpc_mulq (
    input  logic                               clk,
    input  logic [2:0]                         ld,
    input  logic signed [bpc_pkg::MQ_AW-1:0]   a,
    input  logic signed [bpc_pkg::MQ_AW-1:0]   addend,
    input  logic signed [bpc_pkg::SC_W-1:0]    b,
    output logic signed [bpc_pkg::MQ_OW-1:0]   y
);

    localparam int AW = bpc_pkg::MQ_AW;
    localparam int BW = bpc_pkg::SC_W;
    localparam int HW = AW / 2;
    localparam int PW = HW + BW;
    localparam int FW = AW + BW;
    localparam int RW = bpc_pkg::MQ_OW - 1;

    logic signed [AW-1:0] av;
    logic [AW-1:0]        amag_reg;
    logic [BW-1:0]        bmag_reg;
    logic                 neg_reg [0:1];
    logic [PW-1:0]        plo_reg;
    logic [PW-1:0]        phi_reg;
    logic [FW-1:0]        full;
    logic [RW-1:0]        r;
    logic signed [bpc_pkg::MQ_OW-1:0] y_reg;
    logic signed [bpc_pkg::MQ_OW-1:0] y_next;

    // sign and magnitude of both operands
    assign av = a + addend;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            amag_reg   <= av[AW-1] ? AW'(-av) : AW'(av);
            bmag_reg   <= b[BW-1] ? BW'(-b) : BW'(b);
            neg_reg[0] <= av[AW-1] ^ b[BW-1];
        end
    end

    // partial products on the two halves of a
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            plo_reg    <= PW'(amag_reg[HW-1:0]) * PW'(bmag_reg);
            phi_reg    <= PW'(amag_reg[AW-1:HW]) * PW'(bmag_reg);
            neg_reg[1] <= neg_reg[0];
        end
    end

    // combine, round and restore the sign
    always_comb
    begin
        full   = {phi_reg, {HW{1'b0}}} + FW'(plo_reg)
                 + (FW'(1) << (bpc_pkg::FRAC - 1));
        r      = full[bpc_pkg::FRAC +: RW];
        y_next = neg_reg[1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- src/bpc_poly.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_poly
// Calibration polynomials: temperature c0/2 + c1*Tsc and the pressure
// polynomial in Psc and Tsc by Horner's rule, rounded to output units.
// ----------------------------------------------------------------------------
module bpc_poly (
    input  logic                                 clk,
    input  logic [bpc_pkg::POLY_ST-1:0]          ld,
    input  bpc_pkg::coef_t                       coef,
    input  logic signed [bpc_pkg::SC_W-1:0]      tsc,
    input  logic signed [bpc_pkg::SC_W-1:0]      psc,
    input  logic                                 sat_in,
    output logic signed [bpc_pkg::TEMP_W-1:0]    temp,
    output logic signed [bpc_pkg::PRES_W-1:0]    pres,
    output logic                                 sat_out
);

    localparam int AW = bpc_pkg::MQ_AW;
    localparam int OW = bpc_pkg::MQ_OW;
    localparam int SW = bpc_pkg::SUM_W;
    localparam int PRW = SW - (bpc_pkg::FRAC - 4);

    logic signed [AW-1:0]   s1_reg;
    logic signed [AW-1:0]   q3a_reg;
    logic signed [47:0]     tp_reg;
    logic signed [47:0]     c01t_d [0:6];
    logic signed [bpc_pkg::SC_W-1:0]   tsc_d [0:3];
    logic signed [bpc_pkg::SC_W-1:0]   psc_d [0:3];
    logic signed [bpc_pkg::TEMP_W-1:0] t_d   [1:8];
    logic                   sat_d  [0:8];
    logic [47:0]            tmag;
    logic [29:0]            tr;
    logic signed [bpc_pkg::TEMP_W-1:0] t_next;
    logic signed [OW-1:0]   m1;
    logic signed [OW-1:0]   m2;
    logic signed [OW-1:0]   m3;
    logic signed [OW-1:0]   m4;
    logic signed [AW-1:0]   c10_term;
    logic signed [AW-1:0]   zero_term;
    logic signed [SW-1:0]   psum_reg;
    logic [SW-1:0]          pmag;
    logic [PRW-1:0]         pr;
    logic signed [bpc_pkg::PRES_W-1:0] pres_reg;
    logic signed [bpc_pkg::PRES_W-1:0] pres_next;
    logic                   psat;

    // first-order terms against the coefficients
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_reg    <= (AW'(coef.c20) <<< bpc_pkg::FRAC)
                         + AW'(48'(coef.c30) * 48'(psc));
            q3a_reg   <= (AW'(coef.c11) <<< bpc_pkg::FRAC)
                         + AW'(48'(coef.c21) * 48'(psc));
            tp_reg    <= (48'(coef.c0) <<< (bpc_pkg::FRAC - 1))
                         + 48'(coef.c1) * 48'(tsc);
            c01t_d[0] <= 48'(coef.c01) * 48'(tsc);
            tsc_d[0]  <= tsc;
            psc_d[0]  <= psc;
            sat_d[0]  <= sat_in;
        end
    end

    // sample delay lines alongside the multipliers
    for (genvar g = 1; g <= 3; g++)
    begin : g_sc_dly
        always_ff @(posedge clk)
        begin
            if (ld[g])
            begin
                tsc_d[g] <= tsc_d[g-1];
                psc_d[g] <= psc_d[g-1];
            end
        end
    end

    for (genvar g = 1; g <= 6; g++)
    begin : g_c01_dly
        always_ff @(posedge clk)
        begin
            if (ld[g])
            begin
                c01t_d[g] <= c01t_d[g-1];
            end
        end
    end

    for (genvar g = 1; g <= 7; g++)
    begin : g_sat_dly
        always_ff @(posedge clk)
        begin
            if (ld[g])
            begin
                sat_d[g] <= sat_d[g-1];
            end
        end
    end

    // temperature to 1/256 degree, round half away from zero
    always_comb
    begin
        tmag   = tp_reg[47] ? 48'(-tp_reg) : 48'(tp_reg);
        tr     = 30'((tmag + (48'd1 << (bpc_pkg::FRAC - 9))) >> (bpc_pkg::FRAC - 8));
        t_next = tp_reg[47] ? -$signed({2'b00, tr}) : $signed({2'b00, tr});
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            t_d[1] <= t_next;
        end
    end

    for (genvar g = 2; g <= 8; g++)
    begin : g_t_dly
        always_ff @(posedge clk)
        begin
            if (ld[g])
            begin
                t_d[g] <= t_d[g-1];
            end
        end
    end

    // inner Horner step and cross term against Psc
    assign zero_term = '0;
    assign c10_term  = AW'(coef.c10) <<< bpc_pkg::FRAC;

    bpc_mulq u_mq_s (
        .clk    (clk),
        .ld     (ld[3:1]),
        .a      (s1_reg),
        .addend (zero_term),
        .b      (psc_d[0]),
        .y      (m1)
    );

    bpc_mulq u_mq_x (
        .clk    (clk),
        .ld     (ld[3:1]),
        .a      (q3a_reg),
        .addend (zero_term),
        .b      (psc_d[0]),
        .y      (m2)
    );

    // outer Horner step and cross term against Tsc
    bpc_mulq u_mq_h (
        .clk    (clk),
        .ld     (ld[6:4]),
        .a      (m1[AW-1:0]),
        .addend (c10_term),
        .b      (psc_d[3]),
        .y      (m3)
    );

    bpc_mulq u_mq_t (
        .clk    (clk),
        .ld     (ld[6:4]),
        .a      (m2[AW-1:0]),
        .addend (zero_term),
        .b      (tsc_d[3]),
        .y      (m4)
    );

    // sum of the pressure terms
    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            psum_reg <= (SW'(coef.c00) <<< bpc_pkg::FRAC) + SW'(m3) + SW'(m4)
                        + SW'(c01t_d[6]);
        end
    end

    // pressure to 1/16 Pa with rounding and clip
    always_comb
    begin
        pmag = psum_reg[SW-1] ? SW'(-psum_reg) : SW'(psum_reg);
        pr   = PRW'((pmag + (SW'(1) << (bpc_pkg::FRAC - 5))) >> (bpc_pkg::FRAC - 4));
        psat = 1'b0;
        if (!psum_reg[SW-1])
        begin
            if (pr[bpc_pkg::PRES_W-1])
            begin
                pres_next = {1'b0, {(bpc_pkg::PRES_W-1){1'b1}}};
                psat      = 1'b1;
            end
            else
            begin
                pres_next = $signed(pr[bpc_pkg::PRES_W-1:0]);
            end
        end
        else
        begin
            if (pr[bpc_pkg::PRES_W-1] && (|pr[bpc_pkg::PRES_W-2:0]))
            begin
                pres_next = {1'b1, {(bpc_pkg::PRES_W-1){1'b0}}};
                psat      = 1'b1;
            end
            else
            begin
                pres_next = -$signed(pr[bpc_pkg::PRES_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[8])
        begin
            pres_reg <= pres_next;
            sat_d[8] <= sat_d[7] | psat;
        end
    end

    assign temp    = t_d[8];
    assign pres    = pres_reg;
    assign sat_out = sat_d[8];

endmodule

// ----- src/bpc_alt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_alt
// Altitude from compensated pressure: (reference - P) * 0.07874, rounded
// and clipped. Also holds the result register of the pipeline.
// ----------------------------------------------------------------------------
module bpc_alt (
    input  logic                                 clk,
    input  logic [bpc_pkg::ALT_ST-1:0]           ld,
    input  logic signed [bpc_pkg::TEMP_W-1:0]    temp,
    input  logic signed [bpc_pkg::PRES_W-1:0]    pres,
    input  logic                                 sat_in,
    output logic signed [bpc_pkg::TEMP_W-1:0]    temp_out,
    output logic signed [bpc_pkg::PRES_W-1:0]    pres_out,
    output logic signed [bpc_pkg::ALT_W-1:0]     alt_out,
    output logic                                 sat_out
);

    localparam int DFW = bpc_pkg::PRES_W + 2;
    localparam int PW  = 64;
    localparam int AR  = PW - 20;

    logic signed [DFW-1:0] diff;
    logic signed [PW-1:0]  prod_reg;
    logic signed [bpc_pkg::TEMP_W-1:0] temp_reg [0:1];
    logic signed [bpc_pkg::PRES_W-1:0] pres_reg [0:1];
    logic                  sat_reg  [0:1];
    logic [PW-1:0]         amag;
    logic [AR-1:0]         ar;
    logic signed [bpc_pkg::ALT_W-1:0] alt_reg;
    logic signed [bpc_pkg::ALT_W-1:0] alt_next;
    logic                  asat;

    // pressure difference times the altitude factor
    assign diff = $signed(DFW'({1'b0, bpc_pkg::REF_P16})) - DFW'(pres);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            prod_reg    <= PW'(diff) * $signed(PW'({1'b0, bpc_pkg::ALT_K}));
            temp_reg[0] <= temp;
            pres_reg[0] <= pres;
            sat_reg[0]  <= sat_in;
        end
    end

    // round by 2^20 and clip to the output width
    always_comb
    begin
        amag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
        ar   = AR'((amag + (PW'(1) << 19)) >> 20);
        asat = 1'b0;
        if (!prod_reg[PW-1])
        begin
            if (|ar[AR-1:bpc_pkg::ALT_W-1])
            begin
                alt_next = {1'b0, {(bpc_pkg::ALT_W-1){1'b1}}};
                asat     = 1'b1;
            end
            else
            begin
                alt_next = $signed(ar[bpc_pkg::ALT_W-1:0]);
            end
        end
        else
        begin
            if ((|ar[AR-1:bpc_pkg::ALT_W])
                || (ar[bpc_pkg::ALT_W-1] && (|ar[bpc_pkg::ALT_W-2:0])))
            begin
                alt_next = {1'b1, {(bpc_pkg::ALT_W-1){1'b0}}};
                asat     = 1'b1;
            end
            else
            begin
                alt_next = -$signed(ar[bpc_pkg::ALT_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            alt_reg     <= alt_next;
            temp_reg[1] <= temp_reg[0];
            pres_reg[1] <= pres_reg[0];
            sat_reg[1]  <= sat_reg[0] | asat;
        end
    end

    assign temp_out = temp_reg[1];
    assign pres_out = pres_reg[1];
    assign alt_out  = alt_reg;
    assign sat_out  = sat_reg[1];

endmodule

// ----- src/barometer_pressure_temp_compensation_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometer_pressure_temp_compensation_unit
// Barometer compensation: temperature, pressure and altitude from raw
// temperature and pressure samples.
// ----------------------------------------------------------------------------
// The unit is an 18-stage pipeline that takes one request per clock cycle
// unless a stall at the output has backed up to its first stage. Each
// result is presented on the result stream once its request has passed
// through every stage. The depth is set by the sample scaling (a long
// division by the oversampling factor, eight quotient bits per stage), the
// two chained Q.26 multipliers of the pressure polynomial (three stages
// each) and the altitude multiply. A stall holds only the stages that are
// full, so empty stages keep taking requests while a result waits.
// Coefficients and rate codes are written through the cfg port; the user must
// write them only while no request is in flight, the block does not enforce it.
// ----------------------------------------------------------------------------
module barometer_pressure_temp_compensation_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // raw_temperature, raw_pressure
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [111:0]                  m_tdata,   // temperature_out, pressure_out,
                                                     // altitude_out
    output logic                          m_tuser,   // saturated
    // configuration writes
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]     cfg_data
);

    localparam int NS  = bpc_pkg::NUM_STAGES;
    localparam int SST = bpc_pkg::SCALE_ST;
    localparam int PST = bpc_pkg::POLY_ST;

    logic [2:0]            p_rate_reg;
    logic [2:0]            t_rate_reg;
    logic [23:0]           c0_c1_reg;
    logic [39:0]           c00_c10_reg;
    logic [31:0]           c01_c11_reg;
    logic [31:0]           c20_c21_reg;
    logic [15:0]           c30_reg;
    bpc_pkg::coef_t        coef;
    logic [NS-1:0]         valid_reg;
    logic [NS-1:0]         valid_next;
    logic [NS-1:0]         ld;
    logic signed [bpc_pkg::SC_W-1:0]   tsc;
    logic signed [bpc_pkg::SC_W-1:0]   psc;
    logic                  t_sat;
    logic                  p_sat;
    logic signed [bpc_pkg::TEMP_W-1:0] temp_p;
    logic signed [bpc_pkg::PRES_W-1:0] pres_p;
    logic                  sat_p;
    logic signed [bpc_pkg::TEMP_W-1:0] temp_o;
    logic signed [bpc_pkg::PRES_W-1:0] pres_o;
    logic signed [bpc_pkg::ALT_W-1:0]  alt_o;
    logic                  sat_o;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_rate_reg  <= '0;
            t_rate_reg  <= '0;
            c0_c1_reg   <= '0;
            c00_c10_reg <= '0;
            c01_c11_reg <= '0;
            c20_c21_reg <= '0;
            c30_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (bpc_pkg::cfg_index_t'(cfg_index))
                bpc_pkg::CFG_P_RATE:  p_rate_reg  <= cfg_data[2:0];
                bpc_pkg::CFG_T_RATE:  t_rate_reg  <= cfg_data[2:0];
                bpc_pkg::CFG_C0_C1:   c0_c1_reg   <= cfg_data[23:0];
                bpc_pkg::CFG_C00_C10: c00_c10_reg <= cfg_data[39:0];
                bpc_pkg::CFG_C01_C11: c01_c11_reg <= cfg_data[31:0];
                bpc_pkg::CFG_C20_C21: c20_c21_reg <= cfg_data[31:0];
                bpc_pkg::CFG_C30:     c30_reg     <= cfg_data[15:0];
                default:              ;
            endcase
        end
    end

    // coefficient unpacking
    always_comb
    begin
        coef.c0  = $signed(c0_c1_reg[23:12]);
        coef.c1  = $signed(c0_c1_reg[11:0]);
        coef.c00 = $signed(c00_c10_reg[39:20]);
        coef.c10 = $signed(c00_c10_reg[19:0]);
        coef.c01 = $signed(c01_c11_reg[31:16]);
        coef.c11 = $signed(c01_c11_reg[15:0]);
        coef.c20 = $signed(c20_c21_reg[31:16]);
        coef.c21 = $signed(c20_c21_reg[15:0]);
        coef.c30 = $signed(c30_reg);
    end

    // stage load enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        ld[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            ld[i] = !valid_reg[i] || ld[i+1];
        end
        valid_next = valid_reg;
        if (ld[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (ld[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // sample scaling
    bpc_scale u_scale_t (
        .clk  (clk),
        .ld   (ld[SST-1:0]),
        .raw  ($signed(s_tdata[23:0])),
        .code (t_rate_reg),
        .sc   (tsc),
        .sat  (t_sat)
    );

    bpc_scale u_scale_p (
        .clk  (clk),
        .ld   (ld[SST-1:0]),
        .raw  ($signed(s_tdata[47:24])),
        .code (p_rate_reg),
        .sc   (psc),
        .sat  (p_sat)
    );

    // calibration polynomials
    bpc_poly u_poly (
        .clk     (clk),
        .ld      (ld[SST+PST-1:SST]),
        .coef    (coef),
        .tsc     (tsc),
        .psc     (psc),
        .sat_in  (t_sat | p_sat),
        .temp    (temp_p),
        .pres    (pres_p),
        .sat_out (sat_p)
    );

    // altitude and result register
    bpc_alt u_alt (
        .clk      (clk),
        .ld       (ld[NS-1:SST+PST]),
        .temp     (temp_p),
        .pres     (pres_p),
        .sat_in   (sat_p),
        .temp_out (temp_o),
        .pres_out (pres_o),
        .alt_out  (alt_o),
        .sat_out  (sat_o)
    );

    assign s_tready = ld[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {alt_o, pres_o, temp_o};
    assign m_tuser  = sat_o;

    // a full pipeline with a stalled output takes no request
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !m_tready) |-> !s_tready)
        else $error("request taken while pipeline full and stalled");

    // an accepted request occupies the first stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted request lost at pipeline entry");

    // a held middle stage keeps its item
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[SST] && !ld[SST]) |=> valid_reg[SST])
        else $error("stalled stage dropped its item");

    // item count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) <= $past($countones(valid_reg)) + 1)
              && ($countones(valid_reg) + 1 >= $past($countones(valid_reg))))
        else $error("pipeline occupancy jumped");

endmodule
